// File: rtl/grid_ray_wall_traversal_core_macros.svh
// Assertion macros shared by the grid ray caster RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef GRID_RAY_WALL_TRAVERSAL_CORE_MACROS_SVH
`define GRID_RAY_WALL_TRAVERSAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GRWT_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GRWT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: rtl/grwt_pkg.sv
// Package for the grid ray caster: payload structs, state and code types, constants.
// Depends on nothing; imported by grid_ray_wall_traversal_core, its checker and its bench.
`timescale 1ns / 1ps

package grwt_pkg;

   localparam int MAP_SIDE_DEF = 64;
   localparam int FRAC_BITS    = 16;
   localparam int COORD_W      = 10;
   localparam int SIDE_W       = 40;
   localparam int SQ_W         = 52;
   localparam int DIV_TOP      = 14 + FRAC_BITS;
   localparam int SQRT_STEPS   = SQ_W / 2;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_CAST  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_PLAYER_X   = 2'd2,
      CSR_PLAYER_Y   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_SIDE_X,
      S_SIDE_Y,
      S_SIDE_W,
      S_STEP,
      S_CHECK,
      S_SQ_X,
      S_SQ_Y,
      S_SUM,
      S_SQRT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               cmd;
      logic [5:0]         cell_col;
      logic [5:0]         cell_row;
      logic               cell_is_wall;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
   } req_type;

   typedef struct packed {
      logic [31:0]        perp_distance;
      logic [31:0]        cell_distance;
      logic               step_axis;
      logic signed [7:0]  hit_col;
      logic signed [7:0]  hit_row;
      logic               left_map;
   } rsp_type;

endpackage

// File: rtl/grid_ray_wall_traversal_core.sv
// A cast divides for x, then y, forms both side distances and walks the map; every walk
// step is a map read, then a test. It then squares both offsets, sums them and takes the
// square root. The divider, the 32x32 multiplier and the square root unit are shared per
// cast. No request is taken while a cast is in flight; a finished result waits in the
// output register. Reset (synchronous) starts a clearing pass of one map cell a cycle,
// 4096 cells at the default side, during which the input channel takes no transfer.
`timescale 1ns / 1ps

`include "grid_ray_wall_traversal_core_macros.svh"

module grid_ray_wall_traversal_core
   import grwt_pkg::*;
#(
   parameter int MAP_SIDE = MAP_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   localparam int IDX_W  = $clog2(MAP_SIDE);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [8:0] SIDE_LIM = 9'(MAP_SIDE);
   localparam logic [4:0] DIV_START = 5'(DIV_TOP);
   localparam logic [4:0] SQRT_START = 5'(SQRT_STEPS - 1);
   localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

   // Configuration
   logic [6:0]  width_ff, height_ff;
   logic [21:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
         px_ff     <= '0;
         py_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_WIDTH:  width_ff  <= csr_wdata[6:0];
            CSR_MAP_HEIGHT: height_ff <= csr_wdata[6:0];
            CSR_PLAYER_X:   px_ff     <= csr_wdata;
            CSR_PLAYER_Y:   py_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state and datapath registers
   state_type             state_ff, state_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  axis_ff, axis_in;
   logic [16:0]           rem_ff, rem_in;
   logic [DIV_TOP:0]      quo_ff, quo_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [15:0]           mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [31:0]           dlt_x_ff, dlt_x_in, dlt_y_ff, dlt_y_in;
   logic [63:0]           prod_ff, prod_in;
   logic [SIDE_W-1:0]     side_x_ff, side_x_in, side_y_ff, side_y_in, perp_ff, perp_in;
   logic                  side_ff, side_in;
   logic                  left_ff, left_in;
   logic signed [COORD_W-1:0] map_x_ff, map_x_in, map_y_ff, map_y_in;
   logic [SQ_W-1:0]       sq_ff, sq_in, res_ff, res_in, bit_ff, bit_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // Map store
   logic                  mem [0:DEPTH-1];
   logic                  mem_we, mem_wdata, rd_ff;
   logic [ADDR_W-1:0]     mem_waddr, rd_addr;

   // Shared arithmetic
   logic [31:0]           mul_a, mul_b;
   logic [15:0]           div_mag;
   logic [16:0]           rem_sh;
   logic                  div_ge;
   logic                  take_x;
   logic signed [COORD_W-1:0] nx, ny;
   logic [8:0]            eff_w, eff_h;
   logic                  outside;
   logic signed [COORD_W-1:0] off_map;
   logic [21:0]           off_pos;
   logic signed [COORD_W+FRAC_BITS:0] off_diff;
   logic [COORD_W+FRAC_BITS-1:0] off_abs;
   logic [SQ_W-1:0]       sqrt_trial;
   logic [16:0]           frac_sel;
   logic [7:0]            col_ext, row_ext;
   logic                  accept;

   assign accept = req_valid && req_ready;
   assign col_ext = {2'b00, req_data.cell_col};
   assign row_ext = {2'b00, req_data.cell_row};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff    <= cnt_in;
      axis_ff   <= axis_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      dlt_x_ff  <= dlt_x_in;
      dlt_y_ff  <= dlt_y_in;
      prod_ff   <= prod_in;
      side_x_ff <= side_x_in;
      side_y_ff <= side_y_in;
      perp_ff   <= perp_in;
      side_ff   <= side_in;
      left_ff   <= left_in;
      map_x_ff  <= map_x_in;
      map_y_ff  <= map_y_in;
      sq_ff     <= sq_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      // Divider: one quotient bit a cycle of 2^DIV_TOP / magnitude.
      div_mag = axis_ff ? mag_y_ff : mag_x_ff;
      rem_sh  = {rem_ff[15:0], (cnt_ff == DIV_START)};
      div_ge  = rem_sh >= {1'b0, div_mag};

      // Walk step choice and the cell it lands in.
      take_x = side_x_ff < side_y_ff;
      nx = map_x_ff;
      ny = map_y_ff;
      if (take_x) begin
         nx = neg_x_ff ? map_x_ff - COORD_W'(1) : map_x_ff + COORD_W'(1);
      end else begin
         ny = neg_y_ff ? map_y_ff - COORD_W'(1) : map_y_ff + COORD_W'(1);
      end
      rd_addr = {ny[IDX_W-1:0], nx[IDX_W-1:0]};

      eff_w = ({2'b00, width_ff} > SIDE_LIM) ? SIDE_LIM : {2'b00, width_ff};
      eff_h = ({2'b00, height_ff} > SIDE_LIM) ? SIDE_LIM : {2'b00, height_ff};
      outside = map_x_ff[COORD_W-1] || map_y_ff[COORD_W-1]
         || ($unsigned(map_x_ff) >= {1'b0, eff_w})
         || ($unsigned(map_y_ff) >= {1'b0, eff_h});

      // Offset from the player to the stop cell corner, one axis at a time.
      off_map  = (state_ff == S_SQ_X) ? map_x_ff : map_y_ff;
      off_pos  = (state_ff == S_SQ_X) ? px_ff : py_ff;
      off_diff = {off_map[COORD_W-1], off_map, {FRAC_BITS{1'b0}}}
         - {{(COORD_W + FRAC_BITS + 1 - 22){1'b0}}, off_pos};
      off_abs  = off_diff[COORD_W+FRAC_BITS] ? (COORD_W+FRAC_BITS)'(-off_diff)
         : (COORD_W+FRAC_BITS)'(off_diff);

      sqrt_trial = res_ff + bit_ff;

      frac_sel = (state_ff == S_SIDE_X)
         ? (neg_x_ff ? {1'b0, px_ff[FRAC_BITS-1:0]}
                     : 17'h10000 - {1'b0, px_ff[FRAC_BITS-1:0]})
         : (neg_y_ff ? {1'b0, py_ff[FRAC_BITS-1:0]}
                     : 17'h10000 - {1'b0, py_ff[FRAC_BITS-1:0]});

      mul_a = 32'(frac_sel);
      mul_b = (state_ff == S_SIDE_X) ? dlt_x_ff : dlt_y_ff;
      if (state_ff == S_SQ_X || state_ff == S_SQ_Y) begin
         mul_a = 32'(off_abs);
         mul_b = 32'(off_abs);
      end
      prod_in = 64'(mul_a) * 64'(mul_b);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      dlt_x_in     = dlt_x_ff;
      dlt_y_in     = dlt_y_ff;
      side_x_in    = side_x_ff;
      side_y_in    = side_y_ff;
      perp_in      = perp_ff;
      side_in      = side_ff;
      left_in      = left_ff;
      map_x_in     = map_x_ff;
      map_y_in     = map_y_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (cmd_type'(req_data.cmd) == CMD_WRITE) begin
                  // Cells beyond the store are dropped.
                  mem_we    = ({1'b0, col_ext} < SIDE_LIM) && ({1'b0, row_ext} < SIDE_LIM);
                  mem_waddr = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
                  mem_wdata = req_data.cell_is_wall;
               end else begin
                  neg_x_in = req_data.ray_dir_x[15];
                  neg_y_in = req_data.ray_dir_y[15];
                  mag_x_in = req_data.ray_dir_x[15] ? 16'(-req_data.ray_dir_x)
                                                    : req_data.ray_dir_x;
                  mag_y_in = req_data.ray_dir_y[15] ? 16'(-req_data.ray_dir_y)
                                                    : req_data.ray_dir_y;
                  map_x_in = COORD_W'(px_ff[21:FRAC_BITS]);
                  map_y_in = COORD_W'(py_ff[21:FRAC_BITS]);
                  axis_in  = 1'b0;
                  cnt_in   = DIV_START;
                  rem_in   = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in = div_ge ? rem_sh - {1'b0, div_mag} : rem_sh;
            quo_in = {quo_ff[DIV_TOP-1:0], div_ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (!axis_ff) begin
                  dlt_x_in = (div_mag == '0) ? SAT32 : 32'(quo_in);
                  axis_in  = 1'b1;
                  cnt_in   = DIV_START;
                  rem_in   = '0;
               end else begin
                  dlt_y_in = (div_mag == '0) ? SAT32 : 32'(quo_in);
                  state_in = S_SIDE_X;
               end
            end
         end
         S_SIDE_X: begin
            state_in = S_SIDE_Y;
         end
         S_SIDE_Y: begin
            side_x_in = SIDE_W'(prod_ff[48:FRAC_BITS]);
            state_in  = S_SIDE_W;
         end
         S_SIDE_W: begin
            side_y_in = SIDE_W'(prod_ff[48:FRAC_BITS]);
            state_in  = S_STEP;
         end
         S_STEP: begin
            // The map read for the new cell is issued in this cycle.
            if (take_x) begin
               perp_in   = side_x_ff;
               side_x_in = side_x_ff + SIDE_W'(dlt_x_ff);
               side_in   = 1'b0;
            end else begin
               perp_in   = side_y_ff;
               side_y_in = side_y_ff + SIDE_W'(dlt_y_ff);
               side_in   = 1'b1;
            end
            map_x_in = nx;
            map_y_in = ny;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            left_in = outside;
            if (outside || rd_ff) begin
               state_in = S_SQ_X;
            end else begin
               state_in = S_STEP;
            end
         end
         S_SQ_X: begin
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            sq_in    = prod_ff[SQ_W-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            sq_in    = sq_ff + prod_ff[SQ_W-1:0];
            res_in   = '0;
            bit_in   = SQRT_BIT0;
            cnt_in   = SQRT_START;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sq_ff >= sqrt_trial) begin
               sq_in  = sq_ff - sqrt_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.perp_distance = (perp_ff[SIDE_W-1:32] != '0) ? SAT32 : perp_ff[31:0];
               rsp_in.cell_distance = res_ff[31:0];
               rsp_in.step_axis     = side_ff;
               rsp_in.hit_col       = map_x_ff[7:0];
               rsp_in.hit_row       = map_y_ff[7:0];
               rsp_in.left_map      = left_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `GRWT_ASSERT_NEXT(a_cast_starts_divide, clock, reset, accept && req_data.cmd, state_ff == S_DIV)
   `GRWT_ASSERT_NEXT(a_step_then_check, clock, reset, state_ff == S_STEP, state_ff == S_CHECK)
   `GRWT_ASSERT_NEXT(a_done_loads_result, clock, reset, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE)
   `GRWT_ASSERT_IMPLY(a_ready_only_idle, clock, reset, req_ready, state_ff == S_IDLE)

endmodule

// File: dv/grid_ray_wall_traversal_core_checker.sv
// Checker for the grid ray caster: watches both channels and the register port, predicts
// every cast result from its own copy of the map and registers, and counts mismatches.
// Depends on grwt_pkg.
`timescale 1ns / 1ps

module grid_ray_wall_traversal_core_checker
   import grwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata,
   output int          fail_count,
   output int          pending_casts
);

   localparam int SIDE = MAP_SIDE_DEF;

   logic        wall_map [SIDE*SIDE];
   logic [6:0]  cols_in_use;
   logic [6:0]  rows_in_use;
   logic [21:0] eye_x;
   logic [21:0] eye_y;
   rsp_type     cast_results [$];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic logic [63:0] inv_delta(input logic signed [15:0] d);
      logic [63:0] mag;
      logic [63:0] q;
      if (d == 0) return 64'hFFFF_FFFF;
      mag = d < 0 ? 64'(-int'(d)) : 64'(d);
      q = (64'd1 << (14 + FRAC_BITS)) / mag;
      return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type cast_ray(input logic signed [15:0] dx, input logic signed [15:0] dy);
      rsp_type r;
      longint w, h, cx, cy, sxs, sys, ox, oy;
      logic [63:0] ddx, ddy, distx, disty, fr, perp, qx, qy, tot, one;
      logic side, gone, stop;
      one = 64'd1 << FRAC_BITS;
      w = cols_in_use < SIDE ? longint'(cols_in_use) : longint'(SIDE);
      h = rows_in_use < SIDE ? longint'(rows_in_use) : longint'(SIDE);
      cx = longint'(eye_x >> FRAC_BITS);
      cy = longint'(eye_y >> FRAC_BITS);
      ddx = inv_delta(dx);
      ddy = inv_delta(dy);
      fr = eye_x & (one - 1);
      sxs = dx < 0 ? -1 : 1;
      distx = ((dx < 0 ? fr : one - fr) * ddx) >> FRAC_BITS;
      fr = eye_y & (one - 1);
      sys = dy < 0 ? -1 : 1;
      disty = ((dy < 0 ? fr : one - fr) * ddy) >> FRAC_BITS;
      side = 0; gone = 0; stop = 0;
      while (!stop) begin
         if (distx < disty) begin
            distx += ddx; cx += sxs; side = 0;
         end else begin
            disty += ddy; cy += sys; side = 1;
         end
         if (cx < 0 || cx >= w || cy < 0 || cy >= h) begin
            gone = 1; stop = 1;
         end else if (wall_map[cy*SIDE + cx]) begin
            stop = 1;
         end
      end
      perp = side ? disty - ddy : distx - ddx;
      // Offsets stay below 2^32 for every position the registers allow, so squares fit.
      ox = cx * 65536 - longint'(eye_x);
      oy = cy * 65536 - longint'(eye_y);
      if (ox < 0) ox = -ox;
      if (oy < 0) oy = -oy;
      qx = 64'(ox) * 64'(ox);
      qy = 64'(oy) * 64'(oy);
      tot = qx + qy;
      if (tot < qx) tot = '1;
      r.perp_distance = perp > 64'hFFFF_FFFF ? SAT32 : perp[31:0];
      tot = root_floor(tot);
      r.cell_distance = tot > 64'hFFFF_FFFF ? SAT32 : tot[31:0];
      r.step_axis = side;
      r.hit_col = cx[7:0];
      r.hit_row = cy[7:0];
      r.left_map = gone;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (wall_map[i]) wall_map[i] = 1'b0;
         cols_in_use = 7'd64;
         rows_in_use = 7'd64;
         eye_x = '0;
         eye_y = '0;
         cast_results.delete();
         fail_count = 0;
         pending_casts = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MAP_WIDTH:  cols_in_use = csr_wdata[6:0];
               CSR_MAP_HEIGHT: rows_in_use = csr_wdata[6:0];
               CSR_PLAYER_X:   eye_x = csr_wdata;
               CSR_PLAYER_Y:   eye_y = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (cast_results.size() == 0) begin
               report("result transfer with no cast outstanding", 64'd0, 64'd0);
            end else begin
               want = cast_results.pop_front();
               if (rsp_data.perp_distance !== want.perp_distance)
                  report("perp_distance", 64'(rsp_data.perp_distance),
                         64'(want.perp_distance));
               if (rsp_data.cell_distance !== want.cell_distance)
                  report("cell_distance", 64'(rsp_data.cell_distance),
                         64'(want.cell_distance));
               if (rsp_data.step_axis !== want.step_axis)
                  report("step_axis", 64'(rsp_data.step_axis), 64'(want.step_axis));
               if (rsp_data.hit_col !== want.hit_col)
                  report("hit_col", 64'(unsigned'(rsp_data.hit_col)),
                         64'(unsigned'(want.hit_col)));
               if (rsp_data.hit_row !== want.hit_row)
                  report("hit_row", 64'(unsigned'(rsp_data.hit_row)),
                         64'(unsigned'(want.hit_row)));
               if (rsp_data.left_map !== want.left_map)
                  report("left_map", 64'(rsp_data.left_map), 64'(want.left_map));
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.cmd == CMD_WRITE)
               wall_map[req_data.cell_row*SIDE + req_data.cell_col] = req_data.cell_is_wall;
            else
               cast_results.push_back(cast_ray(req_data.ray_dir_x, req_data.ray_dir_y));
         end
         pending_casts = cast_results.size();
      end
   end

endmodule

// File: dv/grid_ray_wall_traversal_core_tb.sv
// Top of the grid ray caster bench: clock, reset, register writes and request stimulus,
// with random idling on both channels. Depends on grwt_pkg, the core and its checker.
`timescale 1ns / 1ps

module grid_ray_wall_traversal_core_tb;
   import grwt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [21:0] csr_wdata = '0;
   int          fail_count;
   int          pending_casts;
   bit          calm = 1'b0;
   bit          hold_results = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   grid_ray_wall_traversal_core uut (.*);

   grid_ray_wall_traversal_core_checker checker_i (.*);

   // Result side: random stalls in bursts, or a long hold while the sender keeps offering.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_results = 1'b0;
         end
         n = $urandom_range(1, 10);
         rsp_ready <= calm || $urandom_range(0, 2) != 0;
         repeat (n) @(posedge clock);
      end
   end

   task automatic send(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_write(input int col, input int row, input bit wall);
      req_type t;
      t = '0;
      t.cmd = CMD_WRITE;
      t.cell_col = 6'(col); t.cell_row = 6'(row); t.cell_is_wall = wall;
      t.ray_dir_x = 16'($urandom); t.ray_dir_y = 16'($urandom);
      send(t);
   endtask

   task automatic send_cast(input logic [15:0] dx, input logic [15:0] dy);
      req_type t;
      t = '0;
      t.cmd = CMD_CAST;
      t.cell_col = 6'($urandom); t.cell_row = 6'($urandom); t.cell_is_wall = 1'($urandom);
      t.ray_dir_x = dx; t.ray_dir_y = dy;
      send(t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_casts != 0) @(posedge clock);
      // A trailing map write may still be in progress.
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [21:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int w, h;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme directions and cells on the default map, player at the corner.
      send_cast(16'h0000, 16'h0000);
      send_cast(16'h7FFF, 16'h0000);
      send_cast(16'h8000, 16'h8000);
      send_cast(16'h0001, 16'hFFFF);
      send_write(63, 63, 1'b1);
      send_write(0, 0, 1'b1);
      send_write(1, 0, 1'b1);
      send_cast(16'h4000, 16'h4000);
      send_cast(16'h4000, 16'h0000);
      send_cast(16'h0000, 16'h4000);
      send_write(1, 0, 1'b0);
      send_cast(16'h4000, 16'h0001);
      drain();
      set_reg(CSR_MAP_WIDTH, 22'd127);
      set_reg(CSR_MAP_HEIGHT, 22'd0);
      set_reg(CSR_PLAYER_X, 22'h3FFFFF);
      set_reg(CSR_PLAYER_Y, 22'h3FFFFF);
      send_cast(16'h7FFF, 16'h7FFF);
      send_cast(16'h8000, 16'h0001);
      drain();
      set_reg(CSR_MAP_WIDTH, 22'd1);
      set_reg(CSR_MAP_HEIGHT, 22'd1);
      set_reg(CSR_PLAYER_X, 22'h08000);
      set_reg(CSR_PLAYER_Y, 22'h00000);
      send_cast(16'hC000, 16'h2000);
      send_cast(16'h2000, 16'hC000);
      drain();

      // Random phases with different map sizes and player positions.
      for (int ph = 0; ph < 16; ph++) begin
         w = (ph % 4 == 0) ? 64 : $urandom_range(1, 64);
         h = (ph % 4 == 1) ? 64 : $urandom_range(1, 64);
         if (ph == 15) calm = 1'b1;
         set_reg(CSR_MAP_WIDTH, ph == 3 ? 22'd127 : 22'(w));
         set_reg(CSR_MAP_HEIGHT, 22'(h));
         set_reg(CSR_PLAYER_X, ph == 7 ? 22'($urandom) : 22'($urandom_range(0, w*65536 - 1)));
         set_reg(CSR_PLAYER_Y, ph == 8 ? 22'($urandom) : 22'($urandom_range(0, h*65536 - 1)));
         if (ph == 2) hold_results = 1'b1;
         for (int i = 0; i < 95; i++) begin
            if ($urandom_range(0, 2) == 0)
               send_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3) == 0);
            else
               send_cast(rand_dir(), rand_dir());
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_casts == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/grwt_pkg.sv
rtl/grid_ray_wall_traversal_core.sv
dv/grid_ray_wall_traversal_core_checker.sv
dv/grid_ray_wall_traversal_core_tb.sv
